FILE: hw/rtl/hva_pkg.sv
// Shared constants and types for the Hadamard variance accumulator.
`timescale 1ns / 1ps

package hva_pkg;

   localparam int DEF_MAX_CLUSTER    = 243;
   localparam int DEF_MAX_SERIES_LEN = 65536;
   localparam int DEF_SAMPLE_BITS    = 12;

   localparam int ACC_BITS  = 63;
   localparam int TERM_BITS = 17;
   localparam logic [ACC_BITS-1:0] ACC_MAX = {ACC_BITS{1'b1}};

   localparam int CSR_IDX_BITS  = 1;
   localparam int CSR_DATA_BITS = 8;
   localparam logic [CSR_IDX_BITS-1:0] CFG_CLUSTER_SIZE = 1'b0;
   localparam logic [CSR_IDX_BITS-1:0] CFG_OVERLAP_MODE = 1'b1;
   localparam logic [CSR_DATA_BITS-1:0] RESET_CLUSTER = 8'd3;

   localparam logic MODE_MAX_OVERLAP = 1'b0;
   localparam logic MODE_TAU_OVERLAP = 1'b1;

   // triplet phase in tau-overlap mode
   localparam logic [1:0] PH_FIRST  = 2'd0;
   localparam logic [1:0] PH_SECOND = 2'd1;
   localparam logic [1:0] PH_THIRD  = 2'd2;

   // result queue, power of two
   localparam int FIFO_DEPTH    = 4;
   localparam int FIFO_PTR_BITS = $clog2(FIFO_DEPTH);
   localparam int FIFO_CNT_BITS = $clog2(FIFO_DEPTH + 1);
   localparam int PEND_BITS     = FIFO_CNT_BITS + 1;

   typedef struct packed {
      logic valid;
      logic last;
      logic drop;
      logic term;
   } ctrl_type;

   typedef struct packed {
      logic [ACC_BITS-1:0]  sum_squares;
      logic [TERM_BITS-1:0] term_count;
      logic                 saturated;
   } res_type;

endpackage

FILE: hw/rtl/hva_window.sv
// Window sums: sample and window-sum memories, counters and second difference.
`timescale 1ns / 1ps

module hva_window
   import hva_pkg::*;
#(
   parameter int MAX_CLUSTER    = DEF_MAX_CLUSTER,
   parameter int MAX_SERIES_LEN = DEF_MAX_SERIES_LEN,
   parameter int SAMPLE_BITS    = DEF_SAMPLE_BITS,
   localparam int TAU_BITS      = $clog2(MAX_CLUSTER + 1),
   localparam int WS_BITS       = SAMPLE_BITS + $clog2(MAX_CLUSTER + 1),
   localparam int DIFF_BITS     = WS_BITS + 2
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        clear_i,
   input  logic [TAU_BITS-1:0]         tau_i,
   input  logic                        mode_i,
   input  logic                        take_i,
   input  logic [SAMPLE_BITS-1:0]      sample_i,
   input  logic                        last_i,
   output logic                        s1_last_o,
   output ctrl_type                    dctrl_o,
   output logic signed [DIFF_BITS-1:0] diff_o
);

   localparam int SLOT_BITS = (MAX_CLUSTER > 1) ? $clog2(MAX_CLUSTER) : 1;
   localparam int SPAN      = 2 * MAX_CLUSTER;
   localparam int WPTR_BITS = $clog2(SPAN);
   localparam int CNT_BITS  = $clog2(MAX_SERIES_LEN + 1);
   localparam int XEXT      = WS_BITS - SAMPLE_BITS;

   logic [SAMPLE_BITS-1:0] samp_mem [MAX_CLUSTER];
   logic [WS_BITS-1:0]     win_mem  [SPAN];

   // stage 0 counters
   logic [CNT_BITS-1:0]  cnt_ff, cnt_in;
   logic [SLOT_BITS-1:0] slot_ff, slot_in;
   logic                 full_ff, full_in;
   logic [WPTR_BITS-1:0] wptr_ff, wptr_in;
   logic                 hist_ff, hist_in;
   logic [1:0]           phase_ff, phase_in;

   logic [SLOT_BITS-1:0] tau_m1;
   logic [WPTR_BITS-1:0] tau_w, span_m1, mid_addr;
   logic                 slot_end, wptr_end, drop, step, is_max, win_act;

   // stage 1
   ctrl_type             s1_ctrl_ff, s1_ctrl_in;
   logic                 s1_step_ff, s1_mode_ff, s1_sub_ff, s1_we_ff, s1_bend_ff;
   logic [1:0]           s1_phase_ff;
   logic [WPTR_BITS-1:0] s1_wptr_ff, s1_mid_ff;
   logic [SAMPLE_BITS-1:0] s1_x_ff, samp_rd_ff;
   logic [WS_BITS-1:0]   win_mid_ff, win_old_ff;

   logic                 fwd_we_ff;
   logic [WPTR_BITS-1:0] fwd_addr_ff;
   logic [WS_BITS-1:0]   fwd_data_ff;

   logic signed [WS_BITS-1:0] ws_ff, ws_in, b0_ff, b1_ff;
   logic signed [WS_BITS-1:0] x_ext, old_samp, ws_sum, mid_v, old_v, a_v, b_v;
   logic signed [DIFF_BITS-1:0] diff_in;

   ctrl_type                    dctrl_ff;
   logic signed [DIFF_BITS-1:0] diff_ff;

   assign tau_m1   = SLOT_BITS'(tau_i - 1'b1);
   assign slot_end = (slot_ff == tau_m1);
   assign tau_w    = WPTR_BITS'(tau_i);
   assign span_m1  = WPTR_BITS'({tau_i, 1'b0} - 1'b1);
   assign wptr_end = (wptr_ff == span_m1);
   assign mid_addr = (wptr_ff >= tau_w) ? (wptr_ff - tau_w) : (wptr_ff + tau_w);
   assign drop     = (cnt_ff == CNT_BITS'(MAX_SERIES_LEN));
   assign step     = take_i && !drop;
   assign is_max   = (mode_i == MODE_MAX_OVERLAP);
   assign win_act  = is_max && (full_ff || slot_end);

   always_comb begin
      cnt_in   = cnt_ff;
      slot_in  = slot_ff;
      full_in  = full_ff;
      wptr_in  = wptr_ff;
      hist_in  = hist_ff;
      phase_in = phase_ff;
      if (step) begin
         cnt_in  = cnt_ff + 1'b1;
         slot_in = slot_end ? '0 : slot_ff + 1'b1;
         full_in = full_ff || slot_end;
         if (win_act) begin
            wptr_in = wptr_end ? '0 : wptr_ff + 1'b1;
            hist_in = hist_ff || wptr_end;
         end
         if (!is_max && slot_end) begin
            case (phase_ff)
               PH_FIRST:  phase_in = PH_SECOND;
               PH_SECOND: phase_in = PH_THIRD;
               default:   phase_in = PH_FIRST;
            endcase
         end
      end
      if (clear_i || (take_i && last_i)) begin
         cnt_in   = '0;
         slot_in  = '0;
         full_in  = 1'b0;
         wptr_in  = '0;
         hist_in  = 1'b0;
         phase_in = PH_FIRST;
      end
   end

   always_comb begin
      s1_ctrl_in.valid = take_i;
      s1_ctrl_in.last  = take_i && last_i;
      s1_ctrl_in.drop  = take_i && drop;
      s1_ctrl_in.term  = step && (is_max ? (win_act && hist_ff)
                                         : (slot_end && phase_ff == PH_THIRD));
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff     <= '0;
         slot_ff    <= '0;
         full_ff    <= 1'b0;
         wptr_ff    <= '0;
         hist_ff    <= 1'b0;
         phase_ff   <= PH_FIRST;
         s1_ctrl_ff <= '0;
         s1_step_ff <= 1'b0;
         s1_we_ff   <= 1'b0;
         s1_bend_ff <= 1'b0;
         s1_sub_ff  <= 1'b0;
         fwd_we_ff  <= 1'b0;
         dctrl_ff   <= '0;
         ws_ff      <= '0;
      end else begin
         cnt_ff     <= cnt_in;
         slot_ff    <= slot_in;
         full_ff    <= full_in;
         wptr_ff    <= wptr_in;
         hist_ff    <= hist_in;
         phase_ff   <= phase_in;
         s1_ctrl_ff <= s1_ctrl_in;
         s1_step_ff <= step;
         s1_we_ff   <= step && win_act;
         s1_bend_ff <= step && !is_max && slot_end;
         s1_sub_ff  <= step && is_max && full_ff;
         fwd_we_ff  <= s1_we_ff;
         dctrl_ff   <= s1_ctrl_ff;
         ws_ff      <= ws_in;
      end
   end

   always_ff @(posedge clock) begin
      s1_mode_ff  <= !is_max;
      s1_phase_ff <= phase_ff;
      s1_wptr_ff  <= wptr_ff;
      s1_mid_ff   <= mid_addr;
      s1_x_ff     <= sample_i;
      fwd_addr_ff <= s1_wptr_ff;
      fwd_data_ff <= ws_sum;
      diff_ff     <= diff_in;
      if (s1_bend_ff && s1_phase_ff == PH_FIRST) begin
         b0_ff <= ws_sum;
      end
      if (s1_bend_ff && s1_phase_ff == PH_SECOND) begin
         b1_ff <= ws_sum;
      end
   end

   // read-first: the old sample of this slot leaves as the new one enters
   always_ff @(posedge clock) begin
      samp_rd_ff <= samp_mem[slot_ff];
      if (step && is_max) begin
         samp_mem[slot_ff] <= sample_i;
      end
   end

   always_ff @(posedge clock) begin
      win_mid_ff <= win_mem[mid_addr];
      win_old_ff <= win_mem[wptr_ff];
      if (s1_we_ff) begin
         win_mem[s1_wptr_ff] <= ws_sum;
      end
   end

   // stage 1: window sum update and second difference
   always_comb begin
      x_ext    = {{XEXT{s1_x_ff[SAMPLE_BITS-1]}}, s1_x_ff};
      old_samp = s1_sub_ff ? {{XEXT{samp_rd_ff[SAMPLE_BITS-1]}}, samp_rd_ff} : '0;
      ws_sum   = ws_ff + x_ext - old_samp;
      // tau of one: the middle window was written in the previous cycle
      mid_v    = (fwd_we_ff && fwd_addr_ff == s1_mid_ff) ? fwd_data_ff : win_mid_ff;
      old_v    = (fwd_we_ff && fwd_addr_ff == s1_wptr_ff) ? fwd_data_ff : win_old_ff;
      a_v      = s1_mode_ff ? b1_ff : mid_v;
      b_v      = s1_mode_ff ? b0_ff : old_v;
      diff_in  = {{2{ws_sum[WS_BITS-1]}}, ws_sum}
               - {a_v[WS_BITS-1], a_v, 1'b0}
               + {{2{b_v[WS_BITS-1]}}, b_v};
      ws_in    = ws_ff;
      if (s1_ctrl_ff.valid && s1_ctrl_ff.last) begin
         ws_in = '0;
      end else if (s1_step_ff) begin
         ws_in = s1_bend_ff ? '0 : ws_sum;
      end
      if (clear_i) begin
         ws_in = '0;
      end
   end

   assign s1_last_o = s1_ctrl_ff.valid && s1_ctrl_ff.last;
   assign dctrl_o   = dctrl_ff;
   assign diff_o    = diff_ff;

`ifndef NO_ASSERTIONS
   a_term_has_window : assert property (@(posedge clock) disable iff (reset)
      (s1_ctrl_ff.term && !s1_mode_ff) |-> s1_we_ff)
      else $error("max-overlap term without window history write");

   a_last_clears : assert property (@(posedge clock) disable iff (reset)
      (take_i && last_i) |=> (cnt_ff == '0 && slot_ff == '0 && wptr_ff == '0 && !hist_ff))
      else $error("series counters not cleared after last sample");
`endif

endmodule

FILE: hw/rtl/hva_square_acc.sv
// Squaring stage and saturating accumulator of second differences.
`timescale 1ns / 1ps

module hva_square_acc
   import hva_pkg::*;
#(
   parameter int DIFF_BITS = DEF_SAMPLE_BITS + $clog2(DEF_MAX_CLUSTER + 1) + 2
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        clear_i,
   input  ctrl_type                    dctrl_i,
   input  logic signed [DIFF_BITS-1:0] diff_i,
   output logic                        q_last_o,
   output logic                        push_o,
   output res_type                     res_o
);

   localparam int SQ_BITS = 2 * DIFF_BITS;

   logic [DIFF_BITS-1:0] mag;
   ctrl_type             q_ctrl_ff;
   logic [SQ_BITS-1:0]   q_sq_ff;

   logic [ACC_BITS-1:0]  acc_ff, acc_in, acc_new;
   logic [TERM_BITS-1:0] terms_ff, terms_in, terms_new;
   logic                 ovf_ff, ovf_in, ovf_new;
   logic [ACC_BITS:0]    sum_w;
   logic                 sat;

   assign mag = diff_i[DIFF_BITS-1] ? (~$unsigned(diff_i) + 1'b1) : $unsigned(diff_i);

   always_ff @(posedge clock) begin
      if (reset) begin
         q_ctrl_ff <= '0;
      end else begin
         q_ctrl_ff <= dctrl_i;
      end
   end

   always_ff @(posedge clock) begin
      q_sq_ff <= mag * mag;
   end

   always_comb begin
      sum_w     = {1'b0, acc_ff} + (ACC_BITS + 1)'(q_sq_ff);
      sat       = sum_w[ACC_BITS];
      acc_new   = acc_ff;
      terms_new = terms_ff;
      ovf_new   = ovf_ff || q_ctrl_ff.drop;
      if (q_ctrl_ff.term) begin
         acc_new   = sat ? ACC_MAX : sum_w[ACC_BITS-1:0];
         terms_new = terms_ff + 1'b1;
         ovf_new   = ovf_ff || q_ctrl_ff.drop || sat;
      end
      acc_in   = acc_ff;
      terms_in = terms_ff;
      ovf_in   = ovf_ff;
      if (q_ctrl_ff.valid) begin
         acc_in   = q_ctrl_ff.last ? '0 : acc_new;
         terms_in = q_ctrl_ff.last ? '0 : terms_new;
         ovf_in   = q_ctrl_ff.last ? 1'b0 : ovf_new;
      end
      if (clear_i) begin
         acc_in   = '0;
         terms_in = '0;
         ovf_in   = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         acc_ff   <= '0;
         terms_ff <= '0;
         ovf_ff   <= 1'b0;
      end else begin
         acc_ff   <= acc_in;
         terms_ff <= terms_in;
         ovf_ff   <= ovf_in;
      end
   end

   assign q_last_o          = q_ctrl_ff.valid && q_ctrl_ff.last;
   assign push_o            = q_ctrl_ff.valid && q_ctrl_ff.last;
   assign res_o.sum_squares = acc_new;
   assign res_o.term_count  = terms_new;
   assign res_o.saturated   = ovf_new;

`ifndef NO_ASSERTIONS
   a_acc_restart : assert property (@(posedge clock) disable iff (reset)
      (q_ctrl_ff.valid && q_ctrl_ff.last) |=> (acc_ff == '0 && terms_ff == '0 && !ovf_ff))
      else $error("accumulator not restarted after result");
`endif

endmodule

FILE: hw/rtl/hva_result_fifo.sv
// Small result queue in front of the response channel.
`timescale 1ns / 1ps

module hva_result_fifo
   import hva_pkg::*;
(
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     push_i,
   input  res_type                  data_i,
   input  logic                     pop_i,
   output logic                     valid_o,
   output res_type                  data_o,
   output logic [FIFO_CNT_BITS-1:0] count_o
);

   res_type                  mem [FIFO_DEPTH];
   logic [FIFO_PTR_BITS-1:0] wr_ptr_ff, wr_ptr_in, rd_ptr_ff, rd_ptr_in;
   logic [FIFO_CNT_BITS-1:0] count_ff, count_in;
   logic                     do_pop;

   assign do_pop = pop_i && (count_ff != '0);

   always_comb begin
      wr_ptr_in = push_i ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = do_pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff;
      if (push_i && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !push_i) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push_i) begin
         mem[wr_ptr_ff] <= data_i;
      end
   end

   assign valid_o = (count_ff != '0);
   assign data_o  = mem[rd_ptr_ff];
   assign count_o = count_ff;

`ifndef NO_ASSERTIONS
   a_no_overflow : assert property (@(posedge clock) disable iff (reset)
      push_i |-> (count_ff < FIFO_CNT_BITS'(FIFO_DEPTH) || do_pop))
      else $error("result queue overflow");

   a_pop_drains : assert property (@(posedge clock) disable iff (reset)
      (do_pop && !push_i) |=> (count_ff == $past(count_ff) - 1'b1))
      else $error("result queue count wrong after pop");
`endif

endmodule

FILE: hw/rtl/hadamard_variance_accumulator.sv
// Top level of the Hadamard variance accumulator: config registers and stream glue.
//
//   channel  dir  handshake             payload
//   req_*    in   req_tvalid/tready     tdata: sample; tlast: last_sample
//   rsp_*    out  rsp_tvalid/tready     tdata: sum_squares, term_count; tuser: saturated
//   csr_*    in   csr_valid/ready       csr_index, csr_data
//
// One sample per cycle while req_tready is high; a result passes the window memory
// read, the difference stage, the multiplier and the accumulator before it leaves.
// Reset is synchronous; no memory clearing pass, entries are written before read.
// req_tready drops only when the 4-entry result queue plus results in flight is full.
// A csr write restarts the series; csr_ready is always high.
`timescale 1ns / 1ps

module hadamard_variance_accumulator
   import hva_pkg::*;
#(
   parameter int MAX_CLUSTER    = DEF_MAX_CLUSTER,
   parameter int MAX_SERIES_LEN = DEF_MAX_SERIES_LEN,
   parameter int SAMPLE_BITS    = DEF_SAMPLE_BITS,
   localparam int REQ_BITS      = ((SAMPLE_BITS + 7) / 8) * 8
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_tvalid,
   output logic                     req_tready,
   input  logic [REQ_BITS-1:0]      req_tdata,   // sample
   input  logic                     req_tlast,
   output logic                     rsp_tvalid,
   input  logic                     rsp_tready,
   output logic [79:0]              rsp_tdata,   // sum_squares, term_count
   output logic                     rsp_tuser,   // saturated
   input  logic                     csr_valid,
   output logic                     csr_ready,
   input  logic [CSR_IDX_BITS-1:0]  csr_index,
   input  logic [CSR_DATA_BITS-1:0] csr_data
);

   localparam int TAU_BITS  = $clog2(MAX_CLUSTER + 1);
   localparam int DIFF_BITS = SAMPLE_BITS + $clog2(MAX_CLUSTER + 1) + 2;

   logic [CSR_DATA_BITS-1:0] cluster_ff, cluster_in;
   logic                     mode_ff, mode_in;
   logic [TAU_BITS-1:0]      tau;
   logic                     take, s1_last, q_last, push;
   ctrl_type                 dctrl;
   logic signed [DIFF_BITS-1:0] diff;
   res_type                  res_push, res_out;
   logic [FIFO_CNT_BITS-1:0] fifo_count;
   logic [PEND_BITS-1:0]     pend;

   assign csr_ready = 1'b1;

   always_comb begin
      cluster_in = cluster_ff;
      mode_in    = mode_ff;
      if (csr_valid) begin
         case (csr_index)
            CFG_CLUSTER_SIZE: cluster_in = csr_data;
            CFG_OVERLAP_MODE: mode_in    = csr_data[0];
            default:          ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cluster_ff <= RESET_CLUSTER;
         mode_ff    <= MODE_MAX_OVERLAP;
      end else begin
         cluster_ff <= cluster_in;
         mode_ff    <= mode_in;
      end
   end

   always_comb begin
      if (cluster_ff == '0) begin
         tau = TAU_BITS'(1);
      end else if (int'(cluster_ff) > MAX_CLUSTER) begin
         tau = TAU_BITS'(MAX_CLUSTER);
      end else begin
         tau = TAU_BITS'(cluster_ff);
      end
   end

   assign pend       = PEND_BITS'(fifo_count) + PEND_BITS'(s1_last)
                     + PEND_BITS'(dctrl.valid && dctrl.last) + PEND_BITS'(q_last);
   assign req_tready = (pend < PEND_BITS'(FIFO_DEPTH));
   assign take       = req_tvalid && req_tready;

   hva_window #(
      .MAX_CLUSTER    (MAX_CLUSTER),
      .MAX_SERIES_LEN (MAX_SERIES_LEN),
      .SAMPLE_BITS    (SAMPLE_BITS)
   ) u_window (
      .clock     (clock),
      .reset     (reset),
      .clear_i   (csr_valid),
      .tau_i     (tau),
      .mode_i    (mode_ff),
      .take_i    (take),
      .sample_i  (req_tdata[SAMPLE_BITS-1:0]),
      .last_i    (req_tlast),
      .s1_last_o (s1_last),
      .dctrl_o   (dctrl),
      .diff_o    (diff)
   );

   hva_square_acc #(
      .DIFF_BITS (DIFF_BITS)
   ) u_square_acc (
      .clock    (clock),
      .reset    (reset),
      .clear_i  (csr_valid),
      .dctrl_i  (dctrl),
      .diff_i   (diff),
      .q_last_o (q_last),
      .push_o   (push),
      .res_o    (res_push)
   );

   hva_result_fifo u_result_fifo (
      .clock   (clock),
      .reset   (reset),
      .push_i  (push),
      .data_i  (res_push),
      .pop_i   (rsp_tready),
      .valid_o (rsp_tvalid),
      .data_o  (res_out),
      .count_o (fifo_count)
   );

   assign rsp_tdata = {res_out.term_count, res_out.sum_squares};
   assign rsp_tuser = res_out.saturated;

endmodule
